// ===== hw/rtl/shell_line_tokenizer_assert.svh =====
// ----------------------------------------------------------------------------
// shell_line_tokenizer_assert.svh
// assertion macros for the shell line tokenizer; NO_ASSERTIONS removes them
// ----------------------------------------------------------------------------
`ifndef SHELL_LINE_TOKENIZER_ASSERT_SVH
`define SHELL_LINE_TOKENIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, clocked on clk, off during reset
`define SLT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shell_line_tokenizer assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define SLT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shell_line_tokenizer assertion failed");

`else

`define SLT_ASSERT_IMP(label, ante, cons)
`define SLT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg
// types and character constants for the shell line tokenizer
// ----------------------------------------------------------------------------
package slt_pkg;

	// lexer mode between bytes
	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_ATOM  = 2'd1,
		MODE_QUOTE = 2'd2
	} lex_mode_t;

	// token kinds as seen on the result port
	typedef enum logic [2:0] {
		KIND_ERROR = 3'd0,
		KIND_EOL   = 3'd1,
		KIND_ATOM  = 3'd2,
		KIND_PIPE  = 3'd3,
		KIND_AMP   = 3'd4,
		KIND_GT    = 3'd5,
		KIND_LT    = 3'd6,
		KIND_SEMI  = 3'd7
	} token_kind_t;

	// one result entry
	typedef struct packed {
		token_kind_t kind;
		logic [11:0] start;
		logic [11:0] length;
		logic        last;
		logic        too_long;
	} tok_t;

	localparam int unsigned OFFSET_W = 12;
	localparam int unsigned CP_W     = 31;

	// characters the lexer reacts to
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;

endpackage

// ===== hw/rtl/shell_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// shell_line_tokenizer
// byte-serial lexer for one shell command line: lenient utf-8 decode, atoms,
// quoted atoms, operators and end of line, with byte start and length
// ----------------------------------------------------------------------------
//
//  channel  signals                                   direction  per request
//  line     line_valid / line_ready / line_byte       in         one raw byte
//  token    token_valid / token_ready / token_kind,   out        one token
//           token_start, token_length, last_of_run,
//           line_too_long
//
// one byte is taken every cycle while the queue has room; it is decoded while
// it sits in the input register, and its zero to two tokens are written into a
// 4-entry result queue, from which a token shows on the token port.
// the queue drains one token a cycle while token_ready is high; a byte's two
// tokens leave in turn, and a full queue (over two entries used) stalls input.
// reset clears the lexer state and empties the queue; a nul byte returns the
// lexer to its reset state after its tokens are queued.
// ----------------------------------------------------------------------------
module shell_line_tokenizer #(
	parameter int unsigned LINE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        line_valid,
	output logic        line_ready,
	input  logic [7:0]  line_byte,
	output logic        token_valid,
	input  logic        token_ready,
	output logic [2:0]  token_kind,
	output logic [11:0] token_start,
	output logic [11:0] token_length,
	output logic        last_of_run,
	output logic        line_too_long
);
	import slt_pkg::*;

	localparam logic [OFFSET_W-1:0] MAX_OFF =
		(LINE_BYTES - 1 > 4095) ? 12'd4095 : OFFSET_W'(LINE_BYTES - 1);
	localparam int unsigned DEPTH = 4;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// lexer state
	lex_mode_t           lex_mode_q;
	logic                cqd_q;
	logic [OFFSET_W-1:0] tok_start_q;
	logic [OFFSET_W-1:0] byte_offset_q;
	logic [OFFSET_W-1:0] char_start_q;
	logic [CP_W-1:0]     pcp_q;
	logic [2:0]          cont_q;
	logic                sat_q;

	// result queue
	tok_t       fifo_q [DEPTH];
	logic [1:0] rd_ptr_q;
	logic [1:0] wr_ptr_q;
	logic [2:0] cnt_q;

	// decode results
	lex_mode_t           lex_mode_d;
	logic                cqd_d;
	logic [OFFSET_W-1:0] tok_start_d;
	logic [OFFSET_W-1:0] byte_offset_d;
	logic [OFFSET_W-1:0] char_start_d;
	logic [CP_W-1:0]     pcp_d;
	logic [2:0]          cont_d;
	logic                sat_d;
	logic                line_end;
	tok_t                r0;
	tok_t                r1;
	logic [1:0]          n_res;

	logic adv;
	logic pop;

	function automatic logic [OFFSET_W-1:0] span(logic [OFFSET_W-1:0] from,
			logic [OFFSET_W-1:0] to);
		return (to > from) ? to - from : '0;
	endfunction

	function automatic logic is_ch(logic [CP_W-1:0] c, logic [7:0] ch);
		return c == {{(CP_W-8){1'b0}}, ch};
	endfunction

	function automatic logic is_sp(logic [CP_W-1:0] c);
		return is_ch(c, CH_SPACE) || is_ch(c, CH_TAB) || is_ch(c, CH_LF) ||
			is_ch(c, CH_VT) || is_ch(c, CH_FF) || is_ch(c, CH_CR);
	endfunction

	// error kind stands for "not an operator"
	function automatic token_kind_t op_of(logic [CP_W-1:0] c);
		token_kind_t k;
		k = KIND_ERROR;
		if (is_ch(c, CH_PIPE)) k = KIND_PIPE;
		if (is_ch(c, CH_AMP))  k = KIND_AMP;
		if (is_ch(c, CH_GT))   k = KIND_GT;
		if (is_ch(c, CH_LT))   k = KIND_LT;
		if (is_ch(c, CH_SEMI)) k = KIND_SEMI;
		return k;
	endfunction

	function automatic tok_t mk(token_kind_t k, logic [OFFSET_W-1:0] s,
			logic [OFFSET_W-1:0] l, logic sat);
		tok_t t;
		t.kind     = k;
		t.start    = s;
		t.length   = l;
		t.last     = 1'b0;
		t.too_long = sat;
		return t;
	endfunction

	// handshakes
	assign adv        = valid_s1 && (cnt_q <= 3'd2);
	assign line_ready = !valid_s1 || adv;
	assign pop        = token_valid && token_ready;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (line_valid && line_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// input byte payload
	always_ff @(posedge clk) begin
		if (line_valid && line_ready) begin
			byte_s1 <= line_byte;
		end
	end

	// utf-8 decode and token formation
	always_comb begin
		logic [OFFSET_W-1:0] pos;
		logic [OFFSET_W-1:0] nxt;
		logic [OFFSET_W-1:0] cstart;
		logic [CP_W-1:0]     cp;
		logic                have;
		lex_mode_t           mode;
		logic [2:0]          a;
		logic [7:0]          mask;
		logic [7:0]          qch;
		token_kind_t         opk;
		tok_t                t;

		pos    = byte_offset_q;
		nxt    = (pos < MAX_OFF) ? pos + 12'd1 : MAX_OFF;
		cstart = pos;
		cp     = '0;
		have   = 1'b0;
		a      = 3'd2;
		mask   = 8'hFF;
		t      = '0;

		unique case (lex_mode_q)
			MODE_ATOM:  mode = MODE_ATOM;
			MODE_QUOTE: mode = MODE_QUOTE;
			default:    mode = MODE_IDLE;
		endcase

		cqd_d        = cqd_q;
		tok_start_d  = tok_start_q;
		char_start_d = char_start_q;
		pcp_d        = pcp_q;
		cont_d       = cont_q;
		line_end     = 1'b0;
		r0           = '0;
		r1           = '0;
		n_res        = 2'd0;

		// character assembly
		if (cont_q != 3'd0) begin
			if (byte_s1 == 8'h00) begin
				if (mode == MODE_IDLE) begin
					mode        = MODE_ATOM;
					tok_start_d = char_start_q;
				end
				cont_d = 3'd0;
				have   = 1'b1;
			end else begin
				pcp_d  = {pcp_q[CP_W-7:0], byte_s1[5:0]};
				cont_d = cont_q - 3'd1;
				if (cont_d == 3'd0) begin
					cp     = pcp_d;
					cstart = char_start_q;
					have   = 1'b1;
				end
			end
		end else if (byte_s1[7:6] == 2'b11) begin
			priority if (!byte_s1[5]) a = 3'd2;
			else if (!byte_s1[4])     a = 3'd3;
			else if (!byte_s1[3])     a = 3'd4;
			else if (!byte_s1[2])     a = 3'd5;
			else                      a = 3'd6;
			if (a < 3'd6 || !byte_s1[1]) begin
				mask         = 8'hFF >> (a + 3'd1);
				pcp_d        = {{(CP_W-8){1'b0}}, byte_s1 & mask};
				cont_d       = a - 3'd1;
				char_start_d = pos;
			end else begin
				cp   = {{(CP_W-8){1'b0}}, byte_s1};
				have = 1'b1;
			end
		end else begin
			cp   = {{(CP_W-8){1'b0}}, byte_s1};
			have = 1'b1;
		end

		// token formation on a whole character
		opk = op_of(cp);
		qch = cqd_q ? CH_DQUOTE : CH_SQUOTE;
		if (have) begin
			if (mode == MODE_QUOTE) begin
				if (cp == '0) begin
					r0       = mk(KIND_ERROR, tok_start_d, span(tok_start_d, cstart), sat_q);
					n_res    = 2'd1;
					line_end = 1'b1;
				end else if (is_ch(cp, qch)) begin
					r0    = mk(KIND_ATOM, tok_start_d, span(tok_start_d, cstart), sat_q);
					n_res = 2'd1;
					mode  = MODE_IDLE;
				end
			end else begin
				if (mode == MODE_ATOM && (cp == '0 || is_sp(cp) || opk != KIND_ERROR)) begin
					r0    = mk(KIND_ATOM, tok_start_d, span(tok_start_d, cstart), sat_q);
					n_res = 2'd1;
					mode  = MODE_IDLE;
				end
				t = '0;
				if (cp == '0) begin
					t        = mk(KIND_EOL, cstart, '0, sat_q);
					line_end = 1'b1;
				end else if (opk != KIND_ERROR) begin
					t = mk(opk, cstart, span(cstart, nxt), sat_q);
				end else if (mode == MODE_IDLE && !is_sp(cp)) begin
					if (is_ch(cp, CH_DQUOTE) || is_ch(cp, CH_SQUOTE)) begin
						mode        = MODE_QUOTE;
						cqd_d       = is_ch(cp, CH_DQUOTE);
						tok_start_d = nxt;
					end else begin
						mode        = MODE_ATOM;
						tok_start_d = cstart;
					end
				end
				// second slot or first, whichever is free
				if (cp == '0 || opk != KIND_ERROR) begin
					if (n_res == 2'd0) begin
						r0    = t;
						n_res = 2'd1;
					end else begin
						r1    = t;
						n_res = 2'd2;
					end
				end
			end
		end

		// mark the last token of this byte
		if (n_res == 2'd1) r0.last = 1'b1;
		if (n_res == 2'd2) r1.last = 1'b1;

		// next state, back to reset after end of line
		if (line_end) begin
			lex_mode_d    = MODE_IDLE;
			cqd_d         = 1'b0;
			tok_start_d   = '0;
			byte_offset_d = '0;
			char_start_d  = '0;
			pcp_d         = '0;
			cont_d        = 3'd0;
			sat_d         = 1'b0;
		end else begin
			lex_mode_d = mode;
			if (byte_offset_q < MAX_OFF) begin
				byte_offset_d = byte_offset_q + 12'd1;
				sat_d         = sat_q;
			end else begin
				byte_offset_d = MAX_OFF;
				sat_d         = 1'b1;
			end
		end
	end

	// lexer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_mode_q    <= MODE_IDLE;
			cqd_q         <= 1'b0;
			tok_start_q   <= '0;
			byte_offset_q <= '0;
			char_start_q  <= '0;
			pcp_q         <= '0;
			cont_q        <= 3'd0;
			sat_q         <= 1'b0;
		end else if (adv) begin
			lex_mode_q    <= lex_mode_d;
			cqd_q         <= cqd_d;
			tok_start_q   <= tok_start_d;
			byte_offset_q <= byte_offset_d;
			char_start_q  <= char_start_d;
			pcp_q         <= pcp_d;
			cont_q        <= cont_d;
			sat_q         <= sat_d;
		end
	end

	// result queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 2'd0;
			wr_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			if (adv) begin
				wr_ptr_q <= wr_ptr_q + n_res;
			end
			cnt_q <= cnt_q + (adv ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
		end
	end

	// result queue entries
	always_ff @(posedge clk) begin
		if (adv && n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= r0;
		end
		if (adv && n_res == 2'd2) begin
			fifo_q[wr_ptr_q + 2'd1] <= r1;
		end
	end

	// result port
	assign token_valid   = cnt_q != 3'd0;
	assign token_kind    = fifo_q[rd_ptr_q].kind;
	assign token_start   = fifo_q[rd_ptr_q].start;
	assign token_length  = fifo_q[rd_ptr_q].length;
	assign last_of_run   = fifo_q[rd_ptr_q].last;
	assign line_too_long = fifo_q[rd_ptr_q].too_long;

	`include "shell_line_tokenizer_assert.svh"

	// queue never overfills
	`SLT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= 3'(DEPTH))
	// offset stays clamped
	`SLT_ASSERT_IMP(a_off_bound, 1'b1, byte_offset_q <= MAX_OFF)
	// saturation flag only with the offset at its ceiling
	`SLT_ASSERT_IMP(a_sat_at_max, sat_q, byte_offset_q == MAX_OFF)
	// end of line puts the lexer back to its reset state
	`SLT_ASSERT_NEXT(a_eol_clear, adv && line_end,
		byte_offset_q == '0 && lex_mode_q == MODE_IDLE && cont_q == 3'd0 && !sat_q)

endmodule
